/* hw/rtl/dss_pkg.sv */
// shared types, codes and constants of the dual stack store
`timescale 1ns / 1ps

package dss_pkg;

   localparam int WORD_W        = 32;
   localparam int OP_W          = 3;
   localparam int CAP_W         = 7;
   localparam int DEPTH_DEFAULT = 64;

   localparam logic [CAP_W-1:0]  CAP_RESET = 7'd64;
   localparam logic [WORD_W-1:0] WORD_MIN  = 32'h8000_0000;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_LO = 3'd0,
      OP_PUSH_HI = 3'd1,
      OP_POP_LO  = 3'd2,
      OP_POP_HI  = 3'd3,
      OP_PEEK_LO = 3'd4,
      OP_PEEK_HI = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_RESP
   } state_type;

   typedef struct packed {
      logic accept;
      logic capture;
   } ctrl_cmd_type;

   typedef struct packed {
      logic needs_read;
   } ctrl_status_type;

endpackage

/* hw/rtl/dss_if.sv */
// handshake channels of the dual stack store: request, response and register write
`timescale 1ns / 1ps

interface dss_req_if;
   logic                           valid;
   logic                           ready;
   logic [dss_pkg::OP_W-1:0]       op;
   logic signed [dss_pkg::WORD_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface dss_rsp_if;
   logic                           valid;
   logic                           ready;
   logic signed [dss_pkg::WORD_W-1:0] data;
   logic                           ok;
   logic                           lower_empty;
   logic                           upper_empty;
   logic                           store_full;

   modport source (output valid, output data, output ok, output lower_empty,
                   output upper_empty, output store_full, input ready);
   modport sink   (input valid, input data, input ok, input lower_empty,
                   input upper_empty, input store_full, output ready);
endinterface

interface dss_csr_if;
   logic                       valid;
   logic                       ready;
   logic [dss_pkg::CAP_W-1:0]  capacity;

   modport source (output valid, output capacity, input ready);
   modport sink   (input valid, input capacity, output ready);
endinterface

/* hw/rtl/dss_ram.sv */
// generic single-port-pair ram with registered read
`timescale 1ns / 1ps

module dss_ram #(
   parameter int WIDTH = dss_pkg::WORD_W,
   parameter int DEPTH = dss_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/dss_ctrl.sv */
// controller: sequences accept, store read and response hand-off
`timescale 1ns / 1ps

module dss_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  dss_pkg::ctrl_status_type status,
   output dss_pkg::ctrl_cmd_type    cmd
);

   dss_pkg::state_type state_ff;
   dss_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dss_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dss_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = status.needs_read ? dss_pkg::S_READ : dss_pkg::S_RESP;
            end
         end
         dss_pkg::S_READ: begin
            state_in = dss_pkg::S_RESP;
         end
         dss_pkg::S_RESP: begin
            if (rsp_ready) begin
               state_in = dss_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dss_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.accept  = 1'b0;
      cmd.capture = 1'b0;
      unique case (state_ff)
         dss_pkg::S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         dss_pkg::S_READ: begin
            cmd.capture = 1'b1;
         end
         dss_pkg::S_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

/* hw/rtl/dss_datapath.sv */
// datapath: stack counts, capacity, shared store and response register
`timescale 1ns / 1ps

module dss_datapath #(
   parameter int DEPTH = dss_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dss_pkg::ctrl_cmd_type         cmd,
   output dss_pkg::ctrl_status_type      status,
   input  logic [dss_pkg::OP_W-1:0]      req_op,
   input  logic [dss_pkg::WORD_W-1:0]    req_value,
   input  logic                          csr_we,
   input  logic [dss_pkg::CAP_W-1:0]     csr_capacity,
   output logic [dss_pkg::WORD_W-1:0]    rsp_data,
   output logic                          rsp_ok,
   output logic                          rsp_lower_empty,
   output logic                          rsp_upper_empty,
   output logic                          rsp_store_full
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int USED_RESET = (int'(dss_pkg::CAP_RESET) > DEPTH) ?
                               DEPTH : int'(dss_pkg::CAP_RESET);

   logic [CNT_W-1:0] lower_cnt_ff, lower_cnt_in;
   logic [CNT_W-1:0] upper_cnt_ff, upper_cnt_in;
   logic [CNT_W-1:0] used_cap_ff,  used_cap_in;

   logic [dss_pkg::WORD_W-1:0] rsp_data_ff, data_in;
   logic rsp_ok_ff, ok_in;
   logic rsp_lower_empty_ff, rsp_upper_empty_ff, rsp_store_full_ff;

   logic [CNT_W:0]            fill_now, fill_next;
   logic                      full_now;
   logic [CNT_W-1:0]          addr_cnt;
   logic                      wr_op, rd_op, needs_read;
   logic [dss_pkg::WORD_W-1:0] ram_rd_data;

   always_comb begin
      if (32'(csr_capacity) > 32'(DEPTH)) begin
         used_cap_in = CNT_W'(DEPTH);
      end else begin
         used_cap_in = CNT_W'(csr_capacity);
      end
   end

   assign fill_now = {1'b0, lower_cnt_ff} + {1'b0, upper_cnt_ff};
   assign full_now = fill_now >= {1'b0, used_cap_ff};

   always_comb begin
      lower_cnt_in = lower_cnt_ff;
      upper_cnt_in = upper_cnt_ff;
      addr_cnt     = '0;
      wr_op        = 1'b0;
      rd_op        = 1'b0;
      ok_in        = 1'b0;
      data_in      = '0;
      unique case (req_op)
         dss_pkg::OP_PUSH_LO: begin
            if (!full_now) begin
               wr_op        = 1'b1;
               addr_cnt     = lower_cnt_ff;
               lower_cnt_in = lower_cnt_ff + CNT_W'(1);
               ok_in        = 1'b1;
            end
         end
         dss_pkg::OP_PUSH_HI: begin
            if (!full_now) begin
               wr_op        = 1'b1;
               addr_cnt     = used_cap_ff - CNT_W'(1) - upper_cnt_ff;
               upper_cnt_in = upper_cnt_ff + CNT_W'(1);
               ok_in        = 1'b1;
            end
         end
         dss_pkg::OP_POP_LO, dss_pkg::OP_PEEK_LO: begin
            if (lower_cnt_ff == '0) begin
               data_in = dss_pkg::WORD_MIN;
            end else begin
               rd_op    = 1'b1;
               addr_cnt = lower_cnt_ff - CNT_W'(1);
               ok_in    = 1'b1;
               if (req_op == dss_pkg::OP_POP_LO) begin
                  lower_cnt_in = lower_cnt_ff - CNT_W'(1);
               end
            end
         end
         dss_pkg::OP_POP_HI, dss_pkg::OP_PEEK_HI: begin
            if (upper_cnt_ff == '0) begin
               data_in = dss_pkg::WORD_MIN;
            end else begin
               rd_op    = 1'b1;
               addr_cnt = used_cap_ff - upper_cnt_ff;
               ok_in    = 1'b1;
               if (req_op == dss_pkg::OP_POP_HI) begin
                  upper_cnt_in = upper_cnt_ff - CNT_W'(1);
               end
            end
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   assign needs_read        = rd_op;
   assign status.needs_read = needs_read;
   assign fill_next = {1'b0, lower_cnt_in} + {1'b0, upper_cnt_in};

   // a register write starts a fresh pair of empty stacks
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_cnt_ff <= '0;
         upper_cnt_ff <= '0;
         used_cap_ff  <= CNT_W'(USED_RESET);
      end else if (csr_we) begin
         lower_cnt_ff <= '0;
         upper_cnt_ff <= '0;
         used_cap_ff  <= used_cap_in;
      end else if (cmd.accept) begin
         lower_cnt_ff <= lower_cnt_in;
         upper_cnt_ff <= upper_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rsp_data_ff        <= data_in;
         rsp_ok_ff          <= ok_in;
         rsp_lower_empty_ff <= lower_cnt_in == '0;
         rsp_upper_empty_ff <= upper_cnt_in == '0;
         rsp_store_full_ff  <= fill_next >= {1'b0, used_cap_ff};
      end else if (cmd.capture) begin
         rsp_data_ff <= ram_rd_data;
      end
   end

   dss_ram #(
      .WIDTH (dss_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.accept && wr_op),
      .wr_addr (addr_cnt[ADDR_W-1:0]),
      .wr_data (req_value),
      .rd_en   (cmd.accept && rd_op),
      .rd_addr (addr_cnt[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rsp_data        = rsp_data_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_lower_empty = rsp_lower_empty_ff;
   assign rsp_upper_empty = rsp_upper_empty_ff;
   assign rsp_store_full  = rsp_store_full_ff;

endmodule

/* hw/rtl/dual_stack_shared_store_unit.sv */
// top level of the dual stack store: two lifo stacks growing towards each other in one ram
//
//  channel  | role   | carries
//  ---------+--------+------------------------------------------------
//  req_ch   | sink   | op (3b), value (32b signed)
//  rsp_ch   | source | data (32b signed), ok, lower_empty, upper_empty, store_full
//  csr_ch   | sink   | capacity (7b), always ready, empties both stacks
//
// a push, a refused op or an empty read presents its response in the cycle after the accept
// a non-empty pop or peek first passes through the read state for the registered ram read
// one item at a time: the next item is taken the cycle after the response is taken
// synchronous active-high reset empties both stacks and sets capacity to 64, or to DEPTH if smaller
// store contents are not cleared by reset; a stalled response holds its payload
`timescale 1ns / 1ps

module dual_stack_shared_store_unit #(
   parameter int DEPTH = dss_pkg::DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   dss_req_if.sink   req_ch,
   dss_rsp_if.source rsp_ch,
   dss_csr_if.sink   csr_ch
);

   dss_pkg::ctrl_cmd_type    cmd;
   dss_pkg::ctrl_status_type status;
   logic                     rsp_valid;
   logic                     req_ready;

   dss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   dss_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_ch.op),
      .req_value       (req_ch.value),
      .csr_we          (csr_ch.valid),
      .csr_capacity    (csr_ch.capacity),
      .rsp_data        (rsp_ch.data),
      .rsp_ok          (rsp_ch.ok),
      .rsp_lower_empty (rsp_ch.lower_empty),
      .rsp_upper_empty (rsp_ch.upper_empty),
      .rsp_store_full  (rsp_ch.store_full)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;
   assign csr_ch.ready = 1'b1;

endmodule

/* hw/rtl/dss_checker.sv */
// port-level checks of the dual stack store, bound to the top level
`timescale 1ns / 1ps

module dss_port_assertions (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [dss_pkg::OP_W-1:0]       req_op,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [dss_pkg::WORD_W-1:0]     rsp_data,
   input logic                           rsp_ok
);

   // a pending response is held until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // one item in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response is pending");

   // pushes never wait on the store read
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_op == dss_pkg::OP_PUSH_LO || req_op == dss_pkg::OP_PUSH_HI)
      |=> rsp_valid)
      else $error("push response not presented in the next cycle");

   // a failed item carries zero or the empty marker
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_data == '0 || rsp_data == dss_pkg::WORD_MIN)
      else $error("failed item carries stray data");

endmodule

bind dual_stack_shared_store_unit dss_port_assertions u_dss_port_assertions (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_op    (req_ch.op),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data),
   .rsp_ok    (rsp_ch.ok)
);
